[hdl/mme_pkg.sv]
// shared constants, types and helpers for the matrix multiply engine
package mme_pkg;

  localparam int MAX_DIM      = 8;
  localparam int ELEM_WIDTH   = 16;
  localparam int RES_WIDTH    = 40;
  localparam int IDX_WIDTH    = 3;
  localparam int CFG_WIDTH    = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIM_BITS     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_CNT_BITS = $clog2(MAX_DIM + 1);
  localparam int ADDR_BITS    = 2 * DIM_BITS;
  localparam int PROD_WIDTH   = 2 * ELEM_WIDTH;
  localparam int SUM_WIDTH    = (PROD_WIDTH > RES_WIDTH) ? PROD_WIDTH : RES_WIDTH;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    op_t                          op;
    logic [IDX_WIDTH-1:0]         elem_row;
    logic [IDX_WIDTH-1:0]         elem_col;
    logic signed [ELEM_WIDTH-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] result_value;
    logic [IDX_WIDTH-1:0]        out_row;
    logic [IDX_WIDTH-1:0]        out_col;
    logic                        last;
  } out_word_t;

  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last_k;
    logic [IDX_WIDTH-1:0] row;
    logic [IDX_WIDTH-1:0] col;
    logic                 last;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [ADDR_BITS-1:0] a_addr;
    logic [ADDR_BITS-1:0] b_addr;
  } issue_t;

  typedef struct packed {
    logic                  a_we;
    logic                  b_we;
    logic [ADDR_BITS-1:0]  addr;
    logic [ELEM_WIDTH-1:0] data;
  } ram_wr_t;

  function automatic logic [DIM_CNT_BITS-1:0] clamp_dim(input logic [CFG_WIDTH-1:0] d);
    logic [DIM_CNT_BITS-1:0] r;
    if (d == '0) begin
      r = DIM_CNT_BITS'(1);
    end else if (d > CFG_WIDTH'(MAX_DIM)) begin
      r = DIM_CNT_BITS'(MAX_DIM);
    end else begin
      r = d[DIM_CNT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/mme_ram.sv]
// generic single write, single read ram with registered read data
module mme_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/mme_mac.sv]
// shared multiply-accumulate unit with result output register
module mme_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  mme_pkg::ctl_t                 ctl_in,
  input  logic [mme_pkg::ELEM_WIDTH-1:0] a_data,
  input  logic [mme_pkg::ELEM_WIDTH-1:0] b_data,
  output logic                          out_valid,
  output mme_pkg::out_word_t            out_data
);

  mme_pkg::ctl_t                          ctl1;
  mme_pkg::ctl_t                          ctl2;
  logic signed [mme_pkg::PROD_WIDTH-1:0]  prod;
  logic signed [mme_pkg::SUM_WIDTH-1:0]   prod_ext;
  logic signed [mme_pkg::RES_WIDTH-1:0]   acc;
  logic signed [mme_pkg::RES_WIDTH-1:0]   acc_next;

  always_comb begin
    prod_ext = mme_pkg::SUM_WIDTH'(prod);
    if (ctl2.first) begin
      acc_next = prod_ext[mme_pkg::RES_WIDTH-1:0];
    end else begin
      acc_next = acc + prod_ext[mme_pkg::RES_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      ctl1      <= ctl_in;
      ctl2      <= ctl1;
      out_valid <= ctl2.valid && ctl2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= signed'(a_data) * signed'(b_data);
      if (ctl2.valid) begin
        acc <= acc_next;
      end
      if (ctl2.valid && ctl2.last_k) begin
        out_data.result_value <= acc_next;
        out_data.out_row      <= ctl2.row;
        out_data.out_col      <= ctl2.col;
        out_data.last         <= ctl2.last;
      end
    end
  end

endmodule

[hdl/mme_seq.sv]
// sequencer: dimension registers, load decode and row/col/inner iteration
module mme_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mme_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mme_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mme_pkg::in_word_t                   in_data,
  input  logic                                adv,
  output mme_pkg::ram_wr_t                    wr,
  output mme_pkg::issue_t                     issue
);

  logic [mme_pkg::CFG_WIDTH-1:0]    rows_in_use;
  logic [mme_pkg::CFG_WIDTH-1:0]    inner_in_use;
  logic [mme_pkg::CFG_WIDTH-1:0]    cols_in_use;
  logic [mme_pkg::DIM_CNT_BITS-1:0] nr;
  logic [mme_pkg::DIM_CNT_BITS-1:0] nk;
  logic [mme_pkg::DIM_CNT_BITS-1:0] nc;
  logic [mme_pkg::DIM_BITS-1:0]     nr_m1;
  logic [mme_pkg::DIM_BITS-1:0]     nk_m1;
  logic [mme_pkg::DIM_BITS-1:0]     nc_m1;
  logic [mme_pkg::DIM_CNT_BITS-1:0] row_ext;
  logic [mme_pkg::DIM_CNT_BITS-1:0] col_ext;
  mme_pkg::state_t                  state;
  mme_pkg::state_t                  state_next;
  logic [mme_pkg::DIM_BITS-1:0]     i_cnt;
  logic [mme_pkg::DIM_BITS-1:0]     i_cnt_next;
  logic [mme_pkg::DIM_BITS-1:0]     j_cnt;
  logic [mme_pkg::DIM_BITS-1:0]     j_cnt_next;
  logic [mme_pkg::DIM_BITS-1:0]     k_cnt;
  logic [mme_pkg::DIM_BITS-1:0]     k_cnt_next;
  logic                             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= mme_pkg::CFG_WIDTH'(mme_pkg::MAX_DIM);
      inner_in_use <= mme_pkg::CFG_WIDTH'(mme_pkg::MAX_DIM);
      cols_in_use  <= mme_pkg::CFG_WIDTH'(mme_pkg::MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mme_pkg::CFG_ROWS:  rows_in_use  <= cfg_data;
        mme_pkg::CFG_INNER: inner_in_use <= cfg_data;
        mme_pkg::CFG_COLS:  cols_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    nr      = mme_pkg::clamp_dim(rows_in_use);
    nk      = mme_pkg::clamp_dim(inner_in_use);
    nc      = mme_pkg::clamp_dim(cols_in_use);
    nr_m1   = mme_pkg::DIM_BITS'(nr - 1'b1);
    nk_m1   = mme_pkg::DIM_BITS'(nk - 1'b1);
    nc_m1   = mme_pkg::DIM_BITS'(nc - 1'b1);
    row_ext = mme_pkg::DIM_CNT_BITS'(in_data.elem_row);
    col_ext = mme_pkg::DIM_CNT_BITS'(in_data.elem_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mme_pkg::ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      i_cnt <= i_cnt_next;
      j_cnt <= j_cnt_next;
      k_cnt <= k_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    i_cnt_next = i_cnt;
    j_cnt_next = j_cnt;
    k_cnt_next = k_cnt;
    in_ready   = 1'b0;
    accept     = 1'b0;
    wr.a_we    = 1'b0;
    wr.b_we    = 1'b0;
    wr.addr    = {in_data.elem_row[mme_pkg::DIM_BITS-1:0],
                  in_data.elem_col[mme_pkg::DIM_BITS-1:0]};
    wr.data    = in_data.element_value;

    issue.ctl.valid  = 1'b0;
    issue.ctl.first  = (k_cnt == '0);
    issue.ctl.last_k = (k_cnt == nk_m1);
    issue.ctl.row    = mme_pkg::IDX_WIDTH'(i_cnt);
    issue.ctl.col    = mme_pkg::IDX_WIDTH'(j_cnt);
    issue.ctl.last   = (i_cnt == nr_m1) && (j_cnt == nc_m1);
    issue.a_addr     = {i_cnt, k_cnt};
    issue.b_addr     = {k_cnt, j_cnt};

    unique case (state)
      mme_pkg::ST_IDLE: begin
        in_ready = !rst;
        accept   = in_valid && !rst;
        if (accept) begin
          case (in_data.op)
            mme_pkg::OP_LOAD_A: begin
              wr.a_we = (row_ext < nr) && (col_ext < nk);
            end
            mme_pkg::OP_LOAD_B: begin
              wr.b_we = (row_ext < nk) && (col_ext < nc);
            end
            mme_pkg::OP_COMPUTE: begin
              state_next = mme_pkg::ST_RUN;
              i_cnt_next = '0;
              j_cnt_next = '0;
              k_cnt_next = '0;
            end
            default: ;
          endcase
        end
      end
      mme_pkg::ST_RUN: begin
        issue.ctl.valid = 1'b1;
        if (adv) begin
          if (k_cnt == nk_m1) begin
            k_cnt_next = '0;
            if (j_cnt == nc_m1) begin
              j_cnt_next = '0;
              if (i_cnt == nr_m1) begin
                state_next = mme_pkg::ST_IDLE;
              end else begin
                i_cnt_next = i_cnt + 1'b1;
              end
            end else begin
              j_cnt_next = j_cnt + 1'b1;
            end
          end else begin
            k_cnt_next = k_cnt + 1'b1;
          end
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

endmodule

[hdl/matrix_multiply_engine_core.sv]
// top level of the matrix multiply engine
//
//  channel   dir  handshake             word
//  in        in   in_valid / in_ready   mme_pkg::in_word_t (op, row, col, value)
//  out       out  out_valid / out_ready mme_pkg::out_word_t (sum, row, col, last)
//  cfg       in   cfg_we                cfg_index, cfg_data
//
// load words write a store through its write port
// compute issues rows * cols * inner multiply-accumulates through the shared mac,
// one per cycle while the output is not stalled
// after the last issue, the last result passes the store read, product and result registers
// in_ready is low during reset and while a compute is issuing
// a stalled output freezes the store read registers, mac pipeline and counters
// synchronous active-high reset clears control; stores are not cleared
module matrix_multiply_engine_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mme_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mme_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mme_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mme_pkg::out_word_t               out_data
);

  logic                           adv;
  mme_pkg::ram_wr_t               wr;
  mme_pkg::issue_t                issue;
  logic [mme_pkg::ELEM_WIDTH-1:0] a_data;
  logic [mme_pkg::ELEM_WIDTH-1:0] b_data;

  assign adv = !out_valid || out_ready;

  mme_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .adv       (adv),
    .wr        (wr),
    .issue     (issue)
  );

  mme_ram #(
    .ADDR_W (mme_pkg::ADDR_BITS),
    .DATA_W (mme_pkg::ELEM_WIDTH)
  ) u_ram_a (
    .clk     (clk),
    .we      (wr.a_we),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (adv),
    .rd_addr (issue.a_addr),
    .rd_data (a_data)
  );

  mme_ram #(
    .ADDR_W (mme_pkg::ADDR_BITS),
    .DATA_W (mme_pkg::ELEM_WIDTH)
  ) u_ram_b (
    .clk     (clk),
    .we      (wr.b_we),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (adv),
    .rd_addr (issue.b_addr),
    .rd_data (b_data)
  );

  mme_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (issue.ctl),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_compute: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == mme_pkg::OP_COMPUTE) |=> !in_ready)
    else $error("ready while compute issuing");

  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    (wr.a_we || wr.b_we) |-> in_ready && in_valid)
    else $error("store written outside an accepted load");

  a_issue_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv && !in_ready |=> $stable(issue))
    else $error("issue moved during output stall");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// testbench for matrix_multiply_engine_core: load/compute words checked against a predictor
module tb;
  import mme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int ADDR_N = MAX_DIM * MAX_DIM;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_WORDS = 24;
  localparam int LONG_HOLD = 300;
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  matrix_multiply_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the stores and dimension registers
  logic signed [ELEM_WIDTH-1:0] a_store [ADDR_N];
  logic signed [ELEM_WIDTH-1:0] b_store [ADDR_N];
  logic [CFG_WIDTH-1:0] dim_reg [3] = '{4'd8, 4'd8, 4'd8};
  out_word_t product_q [$];
  in_word_t feed_q [$];
  int errors = 0;

  // stimulus side view of what has been written
  bit a_set [ADDR_N];
  bit b_set [ADDR_N];
  int gen_rows = MAX_DIM;
  int gen_inner = MAX_DIM;
  int gen_cols = MAX_DIM;
  bit hold_armed = 1'b0;

  function automatic int eff_dim(input logic [CFG_WIDTH-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  task automatic absorb_word(input in_word_t w);
    int nr, nk, nc, r, c;
    logic signed [RES_WIDTH-1:0] acc;
    out_word_t o;
    nr = eff_dim(dim_reg[CFG_ROWS]);
    nk = eff_dim(dim_reg[CFG_INNER]);
    nc = eff_dim(dim_reg[CFG_COLS]);
    r = int'(w.elem_row);
    c = int'(w.elem_col);
    case (w.op)
      OP_LOAD_A: begin
        if (r < nr && c < nk) a_store[r * MAX_DIM + c] = w.element_value;
      end
      OP_LOAD_B: begin
        if (r < nk && c < nc) b_store[r * MAX_DIM + c] = w.element_value;
      end
      OP_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              acc += a_store[i * MAX_DIM + k] * b_store[k * MAX_DIM + j];
            end
            o.result_value = acc;
            o.out_row = IDX_WIDTH'(i);
            o.out_col = IDX_WIDTH'(j);
            o.last = (i == nr - 1) && (j == nc - 1);
            product_q.push_back(o);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("tb: %s mismatch: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) absorb_word(in_data);
      if (out_valid && out_ready) begin
        if (product_q.size() == 0) begin
          report("unexpected word", longint'(out_data.result_value), 0);
        end else begin
          want = product_q.pop_front();
          if (out_data.result_value !== want.result_value)
            report("result_value", longint'(out_data.result_value),
                   longint'(want.result_value));
          if (out_data.out_row !== want.out_row)
            report("out_row", longint'(out_data.out_row), longint'(want.out_row));
          if (out_data.out_col !== want.out_col)
            report("out_col", longint'(out_data.out_col), longint'(want.out_col));
          if (out_data.last !== want.last)
            report("last", longint'(out_data.last), longint'(want.last));
        end
      end
    end
  end

  // sender: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= feed_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, one long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int rx_cnt = 0;
  int hold_cnt = 0;
  bit hold_used = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_cnt <= 0;
      hold_cnt <= 0;
    end else begin
      if (rx_cnt == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_cnt <= $urandom_range(20, 80);
      end else begin
        rx_cnt <= rx_cnt - 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else if (hold_armed && !hold_used && in_valid && in_ready &&
                   in_data.op == OP_COMPUTE) begin
        hold_used <= 1'b1;
        hold_cnt <= LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_HALF: out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  function automatic logic signed [ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [1:0] op, input int r, input int c,
                           input logic signed [ELEM_WIDTH-1:0] v);
    in_word_t w;
    w.op = op_t'(op);
    w.elem_row = IDX_WIDTH'(r);
    w.elem_col = IDX_WIDTH'(c);
    w.element_value = v;
    if (op == OP_LOAD_A && r < gen_rows && c < gen_inner) a_set[r * MAX_DIM + c] = 1'b1;
    if (op == OP_LOAD_B && r < gen_inner && c < gen_cols) b_set[r * MAX_DIM + c] = 1'b1;
    feed_q.push_back(w);
  endtask

  // every entry a compute reads gets written first
  task automatic push_compute();
    for (int i = 0; i < gen_rows; i++)
      for (int k = 0; k < gen_inner; k++)
        if (!a_set[i * MAX_DIM + k]) push_word(OP_LOAD_A, i, k, pick_value());
    for (int k = 0; k < gen_inner; k++)
      for (int j = 0; j < gen_cols; j++)
        if (!b_set[k * MAX_DIM + j]) push_word(OP_LOAD_B, k, j, pick_value());
    push_word(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (feed_q.size() != 0 || in_valid || product_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_WIDTH-1:0] r, input logic [CFG_WIDTH-1:0] k,
                          input logic [CFG_WIDTH-1:0] c);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data <= r;
    @(posedge clk);
    cfg_index <= CFG_INNER;
    cfg_data <= k;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data <= c;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= CFG_WIDTH'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg[CFG_ROWS] = r;
    dim_reg[CFG_INNER] = k;
    dim_reg[CFG_COLS] = c;
    gen_rows = eff_dim(r);
    gen_inner = eff_dim(k);
    gen_cols = eff_dim(c);
  endtask

  initial begin : stim
    int sel, cpct, row_lim, col_lim, r, c;
    logic [1:0] op;
    logic [CFG_WIDTH-1:0] dr, dk, dc;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_dims(4'd2, 4'd3, 4'd2);
    push_word(OP_LOAD_A, 0, 0, ELEM_MIN);
    push_word(OP_LOAD_A, 0, 1, ELEM_MAX);
    push_word(OP_LOAD_A, 0, 2, ELEM_WIDTH'(-1));
    push_word(OP_LOAD_A, 1, 0, ELEM_MIN);
    push_word(OP_LOAD_A, 1, 1, ELEM_WIDTH'(0));
    push_word(OP_LOAD_A, 1, 2, ELEM_MAX);
    push_word(OP_LOAD_B, 0, 0, ELEM_MIN);
    push_word(OP_LOAD_B, 0, 1, ELEM_WIDTH'(-1));
    push_word(OP_LOAD_B, 1, 0, ELEM_MAX);
    push_word(OP_LOAD_B, 1, 1, ELEM_WIDTH'(1));
    push_word(OP_LOAD_B, 2, 0, ELEM_WIDTH'(0));
    push_word(OP_LOAD_B, 2, 1, ELEM_MIN);
    // out of range loads are dropped
    push_word(OP_LOAD_A, 2, 0, ELEM_WIDTH'(5));
    push_word(OP_LOAD_A, 0, 3, ELEM_WIDTH'(5));
    push_word(OP_LOAD_A, 7, 7, ELEM_MAX);
    push_word(OP_LOAD_B, 3, 0, ELEM_WIDTH'(5));
    push_word(OP_LOAD_B, 0, 2, ELEM_WIDTH'(5));
    push_word(OP_LOAD_B, 7, 7, ELEM_MIN);
    push_word(OP_UNUSED, 7, 7, ELEM_WIDTH'(-1));
    push_compute();
    push_word(OP_LOAD_A, 1, 1, ELEM_MAX);
    push_compute();
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin dr = 4'd8; dk = 4'd8; dc = 4'd8; end
        1: begin dr = 4'd1; dk = 4'd1; dc = 4'd1; end
        2: begin dr = 4'd0; dk = 4'd0; dc = 4'd0; end
        3: begin dr = 4'd15; dk = 4'd15; dc = 4'd15; end
        4: begin dr = 4'd1; dk = 4'd8; dc = 4'd1; end
        5: begin dr = 4'd8; dk = 4'd1; dc = 4'd8; end
        default: begin
          dr = CFG_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 4));
          dk = CFG_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 4));
          dc = CFG_WIDTH'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 4));
        end
      endcase
      set_dims(dr, dk, dc);
      hold_armed = (p == 0);
      cpct = (gen_rows * gen_inner * gen_cols > 64) ? 5 : 15;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sel = $urandom_range(0, 99);
        if ((n == 0 && hold_armed) || sel < cpct) begin
          push_compute();
        end else if (sel < cpct + 3) begin
          push_word(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
        end else begin
          op = sel[0] ? OP_LOAD_A : OP_LOAD_B;
          row_lim = (op == OP_LOAD_A) ? gen_rows : gen_inner;
          col_lim = (op == OP_LOAD_A) ? gen_inner : gen_cols;
          r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, row_lim - 1);
          c = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, col_lim - 1);
          push_word(op, r, c, pick_value());
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
